// ----- hw/rtl/mrlm_pkg.sv -----
// Shared types and constants of the message rate and latency monitor.
package mrlm_pkg;

	localparam int WINDOW_DEPTH = 20;
	localparam int MIN_SAMPLES  = 5;

	localparam int TIME_W = 56;
	localparam int CNT_W  = 32;
	localparam int IV_W   = 32;
	localparam int CFG_W  = 16;

	localparam int HEAD_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = IV_W + FILL_W;

	localparam int US_PER_MS  = 1000;
	localparam int RATE_NUM   = 9;
	localparam int RATE_SCALE = 10000000;

	// microsecond limits derived from 16-bit millisecond registers
	localparam int LIM_W = 26;
	// 9 * min_rate_hz
	localparam int K_W   = 20;
	localparam int RHS_W = $clog2(RATE_SCALE * WINDOW_DEPTH + 1);
	// a sum at or above 2**SUM_LO_W always fails a nonzero rate test
	localparam int SUM_LO_W = 28;
	localparam int PROD_W   = SUM_LO_W + K_W;

	localparam int MAX_AGE_RST  = 100;
	localparam int MIN_RATE_RST = 50;
	localparam int STALE_RST    = 2000;

	localparam int IN_W  = 2 * TIME_W;
	localparam int RES_W = 1 + 2 + CNT_W + CNT_W + 1;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - RES_W;

	localparam int OUT_ERR_LSB    = 1;
	localparam int OUT_MCOUNT_LSB = 3;
	localparam int OUT_DCOUNT_LSB = OUT_MCOUNT_LSB + CNT_W;
	localparam int OUT_STALE_BIT  = OUT_DCOUNT_LSB + CNT_W;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_BACKWARDS = 2'd1,
		ERR_TOO_OLD   = 2'd2,
		ERR_RATE_LOW  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		REG_MAX_AGE  = 2'd0,
		REG_MIN_RATE = 2'd1,
		REG_STALE    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_MESSAGE = 1'b0,
		KIND_CHECK   = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t        kind;
		logic [TIME_W-1:0] msg_time;
		logic [TIME_W-1:0] rx_time;
		logic              too_old;
	} item_t;

	typedef struct packed {
		logic             healthy;
		err_t             error_code;
		logic [CNT_W-1:0] msg_count;
		logic [CNT_W-1:0] dropped_count;
		logic             stale;
	} result_t;

endpackage

// ----- hw/rtl/mrlm_stream.sv -----
// Stream state: interval window, running sum, counters and per-word checks.
module mrlm_stream (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mrlm_pkg::item_t         item,
	input  logic                    advance,
	input  logic [mrlm_pkg::K_W-1:0]   rate_k,
	input  logic [mrlm_pkg::LIM_W-1:0] stale_lim,
	output mrlm_pkg::result_t       result
);
	import mrlm_pkg::*;

	logic [TIME_W-1:0] last_msg_q;
	logic [TIME_W-1:0] last_rx_q;
	logic [IV_W-1:0]   win_q [WINDOW_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [HEAD_W-1:0] head_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  acc_q;
	logic [CNT_W-1:0]  drop_q;
	logic              health_q;
	err_t              err_q;

	logic [TIME_W-1:0] last_msg_nxt;
	logic [TIME_W-1:0] last_rx_nxt;
	logic [FILL_W-1:0] fill_nxt;
	logic [HEAD_W-1:0] head_nxt;
	logic [SUM_W-1:0]  sum_nxt;
	logic [CNT_W-1:0]  acc_nxt;
	logic [CNT_W-1:0]  drop_nxt;
	logic              health_nxt;
	err_t              err_nxt;

	logic              rx_gt;
	logic [TIME_W-1:0] rx_diff;
	logic [IV_W-1:0]   iv;
	logic              push;
	logic              full;
	logic [IV_W-1:0]   evict;
	logic [RHS_W-1:0]  rhs;
	logic [PROD_W-1:0] lhs;
	logic              rate_low;
	logic              stale;
	logic              is_msg;

	assign is_msg  = (item.kind == KIND_MESSAGE);
	assign rx_gt   = item.rx_time > last_rx_q;
	assign rx_diff = item.rx_time - last_rx_q;
	// saturate the interval to 32 bits; time going back gives zero
	assign iv = !rx_gt ? '0 : (|rx_diff[TIME_W-1:IV_W]) ? '1 : rx_diff[IV_W-1:0];

	assign full  = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign evict = full ? win_q[head_q] : '0;

	// rate test on the sum after the push: 9*min_hz*sum > 1e7*n
	assign rhs = RHS_W'(RATE_SCALE) * RHS_W'(fill_nxt);
	assign lhs = PROD_W'(rate_k) * PROD_W'(sum_nxt[SUM_LO_W-1:0]);
	assign rate_low = (fill_nxt >= FILL_W'(MIN_SAMPLES)) && (rate_k != '0)
		&& ((|sum_nxt[SUM_W-1:SUM_LO_W]) || (lhs > PROD_W'(rhs)));

	assign stale = !is_msg && (acc_q != '0) && rx_gt
		&& ((|rx_diff[TIME_W-1:LIM_W]) || (rx_diff[LIM_W-1:0] >= stale_lim));

	always_comb begin
		last_msg_nxt = last_msg_q;
		last_rx_nxt  = last_rx_q;
		fill_nxt     = fill_q;
		head_nxt     = head_q;
		sum_nxt      = sum_q;
		acc_nxt      = acc_q;
		drop_nxt     = drop_q;
		health_nxt   = health_q;
		err_nxt      = err_q;
		push         = 1'b0;
		if (is_msg) begin
			if ((last_msg_q != '0) && (item.msg_time < last_msg_q)) begin
				drop_nxt   = (drop_q == '1) ? drop_q : drop_q + 1'b1;
				err_nxt    = ERR_BACKWARDS;
				health_nxt = 1'b0;
			end else begin
				if (last_rx_q != '0) begin
					push     = 1'b1;
					sum_nxt  = sum_q - SUM_W'(evict) + SUM_W'(iv);
					fill_nxt = full ? fill_q : fill_q + 1'b1;
					head_nxt = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
				end
				if (item.too_old) begin
					err_nxt    = ERR_TOO_OLD;
					health_nxt = 1'b0;
				end else if (rate_low) begin
					err_nxt    = ERR_RATE_LOW;
					health_nxt = 1'b0;
				end else begin
					last_msg_nxt = item.msg_time;
					last_rx_nxt  = item.rx_time;
					acc_nxt      = (acc_q == '1) ? acc_q : acc_q + 1'b1;
					health_nxt   = 1'b1;
					err_nxt      = ERR_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_msg_q <= '0;
			last_rx_q  <= '0;
			fill_q     <= '0;
			head_q     <= '0;
			sum_q      <= '0;
			acc_q      <= '0;
			drop_q     <= '0;
			health_q   <= 1'b0;
			err_q      <= ERR_OK;
		end else if (advance) begin
			last_msg_q <= last_msg_nxt;
			last_rx_q  <= last_rx_nxt;
			fill_q     <= fill_nxt;
			head_q     <= head_nxt;
			sum_q      <= sum_nxt;
			acc_q      <= acc_nxt;
			drop_q     <= drop_nxt;
			health_q   <= health_nxt;
			err_q      <= err_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			win_q[head_q] <= iv;
		end
	end

	assign result.healthy       = health_nxt;
	assign result.error_code    = err_nxt;
	assign result.msg_count     = acc_nxt;
	assign result.dropped_count = drop_nxt;
	assign result.stale         = stale;

endmodule

// ----- hw/rtl/message_rate_latency_monitor.sv -----
// Top level of the message rate and latency monitor.
// Words pass the input register, then the output register.
// Throughput: one word per cycle unless m_tready stalls it; stream state
// commits as a word moves on, so each word sees the state its predecessor left.
// Reset (arst_n low, asynchronous): clears the stream state, counters and
// valids, and loads the configuration registers with 100 ms, 50 Hz, 2000 ms.
module message_rate_latency_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	// input word
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mrlm_pkg::IN_W-1:0]     s_tdata,  // message_time_us[55:0], receive_time_us[111:56]
	input  logic                          s_tuser,  // kind[0]
	// result word
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mrlm_pkg::OUT_W-1:0]    m_tdata,  // healthy[0], error_code[2:1],
	                                                // msg_count[34:3], dropped_count[66:35],
	                                                // stale[67], zero[71:68]
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [mrlm_pkg::CFG_W-1:0]    cfg_data
);
	import mrlm_pkg::*;

	// Configuration is held pre-scaled to microseconds so the datapath only
	// compares: age limit = ms*1000, rate factor = 9*Hz, stale limit =
	// (ms+1)*1000 (elapsed/1000 > ms is the same as elapsed >= (ms+1)*1000).
	logic [LIM_W-1:0] max_age_us_q;
	logic [K_W-1:0]   rate_k_q;
	logic [LIM_W-1:0] stale_lim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_us_q <= LIM_W'(MAX_AGE_RST * US_PER_MS);
			rate_k_q     <= K_W'(MIN_RATE_RST * RATE_NUM);
			stale_lim_q  <= LIM_W'((STALE_RST + 1) * US_PER_MS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_AGE: begin
					max_age_us_q <= LIM_W'(cfg_data) * LIM_W'(US_PER_MS);
				end
				REG_MIN_RATE: begin
					rate_k_q <= K_W'(cfg_data) * K_W'(RATE_NUM);
				end
				REG_STALE: begin
					stale_lim_q <= (LIM_W'(cfg_data) + 1'b1) * LIM_W'(US_PER_MS);
				end
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	// Stage 1: input register. The age test needs no stream state, so it is
	// resolved here and travels with the word as one flag.
	logic              s1_valid_q;
	item_t             item_s1;
	logic              out_valid_q;
	logic              adv_out;
	logic [TIME_W-1:0] in_msg;
	logic [TIME_W-1:0] in_rx;
	logic [TIME_W-1:0] age;
	logic              in_too_old;

	assign in_msg = s_tdata[TIME_W-1:0];
	assign in_rx  = s_tdata[IN_W-1:TIME_W];
	assign age    = in_rx - in_msg;
	// a timestamp from the future counts as too old
	assign in_too_old = (in_msg > in_rx) || (|age[TIME_W-1:LIM_W])
		|| (age[LIM_W-1:0] > max_age_us_q);

	// Advance into the output register whenever it is empty or being drained;
	// take a new word whenever stage 1 is empty or moving on.
	assign adv_out  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind     <= item_kind_t'(s_tuser);
			item_s1.msg_time <= in_msg;
			item_s1.rx_time  <= in_rx;
			item_s1.too_old  <= in_too_old;
		end
	end

	// Stage 2: stream state update; its result is captured in the output
	// register on the same edge the state commits.
	result_t res_nxt;
	result_t res_q;

	mrlm_stream u_stream (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.advance   (adv_out),
		.rate_k    (rate_k_q),
		.stale_lim (stale_lim_q),
		.result    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, res_q.stale, res_q.dropped_count,
		res_q.msg_count, res_q.error_code, res_q.healthy};

endmodule

// ----- hw/rtl/mrlm_checker.sv -----
// Port-level checker for the monitor, bound to the top level.
module mrlm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mrlm_pkg::OUT_W-1:0] m_tdata
);
	import mrlm_pkg::*;

	logic [CNT_W-1:0] last_mcount_q;
	logic [CNT_W-1:0] last_dcount_q;
	logic [CNT_W-1:0] mcount;
	logic [CNT_W-1:0] dcount;
	logic [1:0]       err;

	assign mcount = m_tdata[OUT_DCOUNT_LSB-1:OUT_MCOUNT_LSB];
	assign dcount = m_tdata[OUT_STALE_BIT-1:OUT_DCOUNT_LSB];
	assign err    = m_tdata[OUT_MCOUNT_LSB-1:OUT_ERR_LSB];

	// hold the counts of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mcount_q <= '0;
			last_dcount_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_mcount_q <= mcount;
			last_dcount_q <= dcount;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_healthy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> err == ERR_OK)
		else $error("healthy word carries an error code");

	a_mcount_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> mcount >= last_mcount_q)
		else $error("message count went down");

	a_dcount_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> dcount >= last_dcount_q)
		else $error("dropped count went down");

endmodule

bind message_rate_latency_monitor mrlm_checker u_mrlm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
